>>> sv/packet_pixel_line_unpacker_macros.svh
// Assertion macros shared by the packet pixel line unpacker.
`ifndef PACKET_PIXEL_LINE_UNPACKER_MACROS_SVH
`define PACKET_PIXEL_LINE_UNPACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PPLU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pplu_pkg.sv
// Constants, types and geometry lookups for the packet pixel line unpacker.
package pplu_pkg;

  localparam int CHANNELS        = 16;
  localparam int CH_W            = $clog2(CHANNELS);
  localparam int PIXELS_PER_LINE = 7680;
  localparam int PAIRS_PER_LINE  = PIXELS_PER_LINE / 2;
  localparam int PAIR_W          = 12;
  localparam int ADDR_W          = 23;
  localparam int VOTE_W          = 10;
  localparam int MARKERS         = 4;

  localparam logic [15:0]       MIN_PACKET_LEN = 16'd11538;
  localparam logic [VOTE_W-1:0] VOTE_MAX       = 10'd1023;

  // Header byte positions
  localparam logic [15:0] POS_CHAN_HI = 16'd2;
  localparam logic [15:0] POS_CHAN_LO = 16'd3;
  localparam logic [15:0] POS_MARKER  = 16'd9;
  localparam logic [15:0] POS_LINE_HI = 16'd10;
  localparam logic [15:0] POS_LINE_LO = 16'd11;

  // Pixel data start positions
  localparam logic [15:0] START_SHORT = 16'd15;
  localparam logic [15:0] START_LONG  = 16'd16;

  // Mode markers and transmit modes with meaning
  localparam logic [1:0] MARKER_HALF   = 2'd2;
  localparam logic [1:0] MARKER_NARROW = 2'd3;
  localparam logic [3:0] TXMODE_A      = 4'd0;
  localparam logic [3:0] TXMODE_B      = 4'd8;

  // Phase within a three-byte pixel pair
  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_MID  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  // Frame geometry codes; the alias code behaves like the wide full frame
  typedef enum logic [1:0] {
    GEO_WIDE_FULL   = 2'd0,
    GEO_NARROW_FULL = 2'd1,
    GEO_WIDE_HALF   = 2'd2,
    GEO_ALIAS       = 2'd3
  } geo_t;

  function automatic logic [13:0] geo_width(input geo_t g);
    logic [13:0] w;
    unique case (g)
      GEO_NARROW_FULL: w = 14'd7296;
      GEO_WIDE_FULL,
      GEO_WIDE_HALF,
      GEO_ALIAS:       w = 14'd12096;
      default:         w = 14'd12096;
    endcase
    return w;
  endfunction

  function automatic logic [9:0] geo_height(input geo_t g);
    logic [9:0] h;
    unique case (g)
      GEO_WIDE_HALF: h = 10'd374;
      default:       h = 10'd748;
    endcase
    return h;
  endfunction

  function automatic logic [15:0] geo_limit(input geo_t g);
    logic [15:0] l;
    unique case (g)
      GEO_WIDE_HALF: l = 16'd588;
      default:       l = 16'd710;
    endcase
    return l;
  endfunction

  function automatic logic in_vote_window(input logic [15:0] ln);
    return (ln > 16'd50 && ln < 16'd70) || (ln > 16'd500 && ln < 16'd520) ||
           (ln > 16'd700 && ln < 16'd720);
  endfunction

endpackage

>>> sv/packet_pixel_line_unpacker.sv
// Top level of the packet pixel line unpacker: header decode, pixel unpack, frame voting.
// The block takes one payload byte per cycle and gives at most one result per byte, a
// pixel write, a finished-frame report or both. A byte is held in the input
// register, where header decode, pixel unpacking and the per-channel vote update run in
// one pass, and its result is registered in the output register before it is offered.
// The sustained rate is one byte per cycle; the only stall comes from the result side
// holding out_ready low. The line base address (line times the line pitch) is formed by
// one multiplier when the line number bytes arrive and is registered before the pixel
// bytes use it. Per-channel votes, modes and geometry live in flip-flops and are cleared
// at reset.
module packet_pixel_line_unpacker
  import pplu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pixel_valid,
  output logic [15:0] out_pixel_value,
  output logic [22:0] out_pixel_address,
  output logic [3:0]  out_source_channel,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_mode,
  output logic [13:0] out_frame_width,
  output logic [9:0]  out_frame_height
);

`include "packet_pixel_line_unpacker_macros.svh"

  // Input register
  logic        in_v_r;
  logic [7:0]  byte_r;
  logic        first_r;
  logic        last_r;
  logic [15:0] len_r;

  // Packet state
  logic [15:0]       pos_r,   pos_nxt;
  logic              drop_r,  drop_nxt;
  logic [3:0]        ch_r,    ch_nxt;
  logic [15:0]       line_r,  line_nxt;
  logic [1:0]        mark_r,  mark_nxt;
  logic [3:0]        tmode_r, tmode_nxt;
  logic [7:0]        held_r,  held_nxt;
  logic [PAIR_W-1:0] pair_r,  pair_nxt;
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] base_r,  base_nxt;

  // Per-channel state
  logic [VOTE_W-1:0] vote_r [CHANNELS][MARKERS];
  logic [1:0]        mode_r [CHANNELS];
  geo_t              geo_r  [CHANNELS];

  // Output register
  logic              out_v_r;
  logic              pix_r;
  logic [15:0]       pval_r;
  logic [ADDR_W-1:0] paddr_r;
  logic [3:0]        och_r;
  logic              done_r;
  logic [1:0]        fmode_r;
  logic [13:0]       fw_r;
  logic [9:0]        fh_r;

  // Working signals
  logic [15:0]       pos_cur, line_cur;
  logic              drop_cur;
  logic [3:0]        ch_cur, tmode_cur;
  logic [1:0]        mark_cur;
  logic [7:0]        held_cur;
  logic [PAIR_W-1:0] pair_cur;
  phase_t            phase_cur;
  logic [ADDR_W-1:0] base_cur;
  logic [CH_W-1:0]   slot;
  geo_t              geo;
  logic [15:0]       start_pos;
  logic [15:0]       limit;
  logic [11:0]       px;
  logic              pix, done, produce, adv, end_pkt;
  logic [15:0]       pval;
  logic [ADDR_W-1:0] paddr;
  logic [1:0]        fmode;
  logic [13:0]       fw;
  logic [9:0]        fh;
  logic [VOTE_W-1:0] row   [MARKERS];
  logic [VOTE_W-1:0] row_nxt [MARKERS];
  logic [VOTE_W-1:0] best_cnt;
  logic [1:0]        best;
  logic [1:0]        mode_nxt;
  geo_t              geo_upd;

  // Decode the held byte against packet state
  always_comb begin
    // Start a packet on the first byte
    pos_cur   = first_r ? 16'd0 : pos_r;
    drop_cur  = first_r ? (len_r < MIN_PACKET_LEN) : drop_r;
    ch_cur    = first_r ? 4'd0 : ch_r;
    line_cur  = first_r ? 16'd0 : line_r;
    mark_cur  = first_r ? 2'd0 : mark_r;
    tmode_cur = first_r ? 4'd0 : tmode_r;
    held_cur  = first_r ? 8'd0 : held_r;
    pair_cur  = first_r ? '0 : pair_r;
    phase_cur = first_r ? PH_LOW : phase_r;
    base_cur  = first_r ? '0 : base_r;

    pos_nxt   = pos_cur;
    drop_nxt  = drop_cur;
    ch_nxt    = ch_cur;
    line_nxt  = line_cur;
    mark_nxt  = mark_cur;
    tmode_nxt = tmode_cur;
    held_nxt  = held_cur;
    pair_nxt  = pair_cur;
    phase_nxt = phase_cur;
    base_nxt  = base_cur;

    pix   = 1'b0;
    pval  = '0;
    paddr = '0;
    px    = '0;
    done  = 1'b0;
    fmode = '0;
    fw    = '0;
    fh    = '0;
    best  = '0;
    best_cnt = '0;
    mode_nxt = '0;
    geo_upd  = GEO_WIDE_FULL;
    end_pkt  = 1'b0;
    for (int m = 0; m < MARKERS; m++) begin
      row[m]     = '0;
      row_nxt[m] = '0;
    end

    if (!drop_cur) begin
      // Pick header fields
      unique case (pos_cur)
        POS_CHAN_HI: begin
          ch_nxt    = {byte_r[2:0], 1'b0};
          tmode_nxt = {byte_r[1:0], 2'b00};
        end
        POS_CHAN_LO: begin
          ch_nxt    = ch_cur | {3'b000, byte_r[7]};
          tmode_nxt = tmode_cur | {2'b00, byte_r[7:6]};
        end
        POS_MARKER:  mark_nxt = byte_r[1:0];
        POS_LINE_HI: line_nxt = {byte_r, 8'h00};
        POS_LINE_LO: line_nxt = {line_cur[15:8], byte_r};
        default: ;
      endcase
      if (pos_cur == POS_LINE_HI || pos_cur == POS_LINE_LO) begin
        base_nxt = ADDR_W'(32'(line_nxt) * 32'(PIXELS_PER_LINE));
      end
    end

    slot  = ch_nxt[CH_W-1:0];
    geo   = geo_r[slot];
    limit = geo_limit(geo);
    start_pos = (mark_nxt == MARKER_HALF && (tmode_nxt == TXMODE_A || tmode_nxt == TXMODE_B))
              ? START_SHORT : START_LONG;

    if (!drop_cur) begin
      // Unpack two 12-bit pixels from each three bytes
      if (pos_cur >= start_pos && pair_cur < PAIR_W'(PAIRS_PER_LINE)) begin
        unique case (phase_cur)
          PH_LOW: begin
            held_nxt  = byte_r;
            phase_nxt = PH_MID;
          end
          PH_MID: begin
            px        = {byte_r[3:0], held_cur};
            pix       = (line_nxt <= limit);
            paddr     = base_cur + ADDR_W'({pair_cur, 1'b0});
            held_nxt  = byte_r;
            phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            px        = {byte_r, held_cur[7:4]};
            pix       = (line_nxt <= limit);
            paddr     = base_cur + ADDR_W'({pair_cur, 1'b1});
            pair_nxt  = pair_cur + PAIR_W'(1);
            phase_nxt = PH_LOW;
          end
          default: phase_nxt = PH_LOW;
        endcase
        if (pix) begin
          pval = {px, 4'h0};
        end else begin
          paddr = '0;
        end
      end

      // Advance the byte position, saturating
      if (pos_cur != 16'hFFFF) begin
        pos_nxt = pos_cur + 16'd1;
      end

      // Close the packet: frame report, mode vote, marker count
      if (last_r) begin
        end_pkt  = 1'b1;
        drop_nxt = 1'b1;
        for (int m = 0; m < MARKERS; m++) begin
          row[m] = vote_r[slot][m];
        end
        if (line_nxt == limit) begin
          done  = 1'b1;
          fmode = mode_r[slot];
          fw    = geo_width(geo);
          fh    = geo_height(geo);
          for (int m = 0; m < MARKERS; m++) begin
            row[m] = '0;
          end
        end
        mode_nxt = mode_r[slot];
        geo_upd  = geo;
        if (in_vote_window(line_nxt)) begin
          best_cnt = row[0];
          for (int m = 1; m < MARKERS; m++) begin
            if (row[m] > best_cnt) begin
              best_cnt = row[m];
              best     = 2'(m);
            end
          end
          if (best_cnt != '0) begin
            mode_nxt = best;
            if (best == MARKER_NARROW) begin
              geo_upd = GEO_NARROW_FULL;
            end else if (best == MARKER_HALF) begin
              geo_upd = GEO_WIDE_HALF;
            end
          end
        end
        for (int m = 0; m < MARKERS; m++) begin
          row_nxt[m] = row[m];
        end
        if (row[mark_nxt] < VOTE_MAX) begin
          row_nxt[mark_nxt] = row[mark_nxt] + VOTE_W'(1);
        end
      end
    end

    produce = pix || done;
  end

  // Handshake: move the held byte on unless its result finds the output full and out_ready low
  assign adv      = in_v_r && (!produce || !out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_payload_byte;
      first_r <= in_first_byte;
      last_r  <= in_last_byte;
      len_r   <= in_payload_length;
    end
  end

  // Packet and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      drop_r  <= 1'b0;
      ch_r    <= '0;
      line_r  <= '0;
      mark_r  <= '0;
      tmode_r <= '0;
      held_r  <= '0;
      pair_r  <= '0;
      phase_r <= PH_LOW;
      base_r  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        mode_r[c] <= '0;
        geo_r[c]  <= GEO_WIDE_FULL;
        for (int m = 0; m < MARKERS; m++) begin
          vote_r[c][m] <= '0;
        end
      end
    end else if (adv) begin
      pos_r   <= pos_nxt;
      drop_r  <= drop_nxt;
      ch_r    <= ch_nxt;
      line_r  <= line_nxt;
      mark_r  <= mark_nxt;
      tmode_r <= tmode_nxt;
      held_r  <= held_nxt;
      pair_r  <= pair_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      if (end_pkt) begin
        mode_r[slot] <= mode_nxt;
        geo_r[slot]  <= geo_upd;
        for (int m = 0; m < MARKERS; m++) begin
          vote_r[slot][m] <= row_nxt[m];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && produce) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      pix_r   <= pix;
      pval_r  <= pval;
      paddr_r <= paddr;
      och_r   <= ch_nxt;
      done_r  <= done;
      fmode_r <= fmode;
      fw_r    <= fw;
      fh_r    <= fh;
    end
  end

  assign out_valid          = out_v_r;
  assign out_pixel_valid    = pix_r;
  assign out_pixel_value    = pval_r;
  assign out_pixel_address  = paddr_r;
  assign out_source_channel = och_r;
  assign out_frame_done     = done_r;
  assign out_frame_mode     = fmode_r;
  assign out_frame_width    = fw_r;
  assign out_frame_height   = fh_r;

  // Checks
  `PPLU_ASSERT_NOW(a_result_has_content, clk, rst_n, out_v_r, pix_r || done_r, "empty result")
  `PPLU_ASSERT_NOW(a_pair_in_range, clk, rst_n, 1'b1,
                   pair_r <= PAIR_W'(PAIRS_PER_LINE), "pair overrun")
  `PPLU_ASSERT_NEXT(a_stall_holds_pos, clk, rst_n, in_v_r && !adv,
                    $stable(pos_r) && in_v_r, "stall moved state")
  `PPLU_ASSERT_NOW(a_frame_geometry, clk, rst_n, out_v_r && done_r,
                   (fh_r == 10'd374 && fw_r == 14'd12096) ||
                   (fh_r == 10'd748 && (fw_r == 14'd12096 || fw_r == 14'd7296)),
                   "bad frame geometry")

endmodule
